### hw/rtl/wepp_pkg.sv
// ----------------------------------------------------------------------------
// Wall edge projector package
// Shared types and constants of the wall edge perspective projector.
// ----------------------------------------------------------------------------
package wepp_pkg;

    localparam int TRIG_W   = 16;
    localparam int FOV_W    = 16;
    localparam int CTR_W    = 12;
    localparam int OUT_W    = 16;
    localparam int QBITS    = 17;
    localparam int DIV_LAT  = QBITS + 1;
    localparam int QDEPTH   = 4;
    localparam int REG_AW   = 3;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam logic signed [TRIG_W-1:0] COS_RESET  = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] SIN_RESET  = 16'sd0;
    localparam logic [FOV_W-1:0]         FOV_RESET  = 16'd39114;
    localparam logic [CTR_W-1:0]         HW_RESET   = 12'd480;
    localparam logic [CTR_W-1:0]         HH_RESET   = 12'd270;
    localparam int                       EYE_RESET  = 512;

    typedef enum logic [REG_AW-1:0] {
        REG_PLAYER_X   = 3'd0,
        REG_PLAYER_Y   = 3'd1,
        REG_COS_ANGLE  = 3'd2,
        REG_SIN_ANGLE  = 3'd3,
        REG_EYE_HEIGHT = 3'd4,
        REG_FOV_SCALE  = 3'd5,
        REG_HALF_WIDTH = 3'd6,
        REG_HALF_HEIGHT = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_angle;
        logic signed [TRIG_W-1:0] sin_angle;
        logic [FOV_W-1:0]         fov_scale;
        logic [CTR_W-1:0]         half_width;
        logic [CTR_W-1:0]         half_height;
    } t_view_cfg;

endpackage

### hw/rtl/wall_edge_perspective_projector_core.sv
// ----------------------------------------------------------------------------
// Wall edge perspective projector
// Projects one wall edge per item to screen columns and ceiling/floor rows.
// ----------------------------------------------------------------------------
// An item is taken in every cycle in which start is high and busy is low, and
// its result appears on the o_ ports with o_valid high for one cycle, after
// passing through the view transform, the edge queue and the eighteen stage
// quotient pipelines of the back end. Results must be taken when shown. The
// user must write configuration registers through the APB port only while
// no item is in flight; the block itself does not enforce this.
module wall_edge_perspective_projector_core
    import wepp_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_floor_level,
    input  logic signed [COORD_WIDTH-1:0] i_ceiling_level,
    output logic                          o_valid,
    output logic                          o_visible,
    output logic signed [OUT_W-1:0]       o_screen_x_start,
    output logic signed [OUT_W-1:0]       o_screen_x_end,
    output logic signed [OUT_W-1:0]       o_ceil_y_start,
    output logic signed [OUT_W-1:0]       o_floor_y_start,
    output logic signed [OUT_W-1:0]       o_ceil_y_end,
    output logic signed [OUT_W-1:0]       o_floor_y_end,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [PDATA_W-1:0]            pwdata,
    output logic [PDATA_W-1:0]            prdata,
    output logic                          pready
);

    localparam int CW = COORD_WIDTH;
    localparam int QW = 1 + 4 + 4 * (CW + 17) + 2 * CW;

    logic signed [CW-1:0] r_player_x, r_player_y, r_eye_height;
    t_view_cfg            r_view;
    t_reg_idx             w_idx;
    logic                 w_wr;

    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player_x   <= '0;
            r_player_y   <= '0;
            r_eye_height <= CW'(EYE_RESET);
            r_view.cos_angle   <= COS_RESET;
            r_view.sin_angle   <= SIN_RESET;
            r_view.fov_scale   <= FOV_RESET;
            r_view.half_width  <= HW_RESET;
            r_view.half_height <= HH_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_PLAYER_X:    r_player_x   <= pwdata[CW-1:0];
                REG_PLAYER_Y:    r_player_y   <= pwdata[CW-1:0];
                REG_COS_ANGLE:   r_view.cos_angle <= pwdata[TRIG_W-1:0];
                REG_SIN_ANGLE:   r_view.sin_angle <= pwdata[TRIG_W-1:0];
                REG_EYE_HEIGHT:  r_eye_height <= pwdata[CW-1:0];
                REG_FOV_SCALE:   r_view.fov_scale <= pwdata[FOV_W-1:0];
                REG_HALF_WIDTH:  r_view.half_width <= pwdata[CTR_W-1:0];
                REG_HALF_HEIGHT: r_view.half_height <= pwdata[CTR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PLAYER_X:    prdata = PDATA_W'(unsigned'(r_player_x));
            REG_PLAYER_Y:    prdata = PDATA_W'(unsigned'(r_player_y));
            REG_COS_ANGLE:   prdata = PDATA_W'(unsigned'(r_view.cos_angle));
            REG_SIN_ANGLE:   prdata = PDATA_W'(unsigned'(r_view.sin_angle));
            REG_EYE_HEIGHT:  prdata = PDATA_W'(unsigned'(r_eye_height));
            REG_FOV_SCALE:   prdata = PDATA_W'(r_view.fov_scale);
            REG_HALF_WIDTH:  prdata = PDATA_W'(r_view.half_width);
            REG_HALF_HEIGHT: prdata = PDATA_W'(r_view.half_height);
            default:         prdata = '0;
        endcase
    end

    logic          w_accept, w_push, w_qv, w_afull;
    logic [QW-1:0] w_word, w_qdata;

    assign w_accept = start && !busy;
    assign busy     = w_afull;

    wepp_front #(.CW(CW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(w_accept),
        .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_end_x(i_end_x), .i_end_y(i_end_y),
        .i_floor_level(i_floor_level), .i_ceiling_level(i_ceiling_level),
        .i_player_x(r_player_x), .i_player_y(r_player_y),
        .i_eye_height(r_eye_height), .i_view(r_view),
        .o_push(w_push), .o_word(w_word));

    wepp_queue #(.WIDTH(QW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_data(w_word),
        .o_valid(w_qv), .o_data(w_qdata), .o_almost_full(w_afull));

    wepp_back #(.CW(CW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .i_word(w_qdata),
        .i_view(r_view), .o_valid(o_valid), .o_visible(o_visible),
        .o_screen_x_start(o_screen_x_start), .o_screen_x_end(o_screen_x_end),
        .o_ceil_y_start(o_ceil_y_start), .o_floor_y_start(o_floor_y_start),
        .o_ceil_y_end(o_ceil_y_end), .o_floor_y_end(o_floor_y_end));

endmodule

### hw/rtl/wepp_div.sv
// ----------------------------------------------------------------------------
// Pipelined quotient unit
// Restoring division, one quotient bit per stage, with overflow detection.
// ----------------------------------------------------------------------------
module wepp_div
    import wepp_pkg::*;
#(
    parameter int NW = 40,
    parameter int DW = 24
) (
    input  logic              i_clk,
    input  logic [NW-1:0]     i_num,
    input  logic [DW-1:0]     i_den,
    output logic [QBITS-1:0]  o_quot,
    output logic              o_inexact,
    output logic              o_sat
);

    localparam int XW = NW + DW + QBITS + 1;

    logic [XW-1:0]    r_rem [0:QBITS];
    logic [QBITS-1:0] r_q   [0:QBITS];
    logic [DW-1:0]    r_d   [0:QBITS];
    logic             r_sat [0:QBITS];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= XW'(i_num);
        r_d[0]   <= i_den;
        r_q[0]   <= '0;
        r_sat[0] <= (XW'(i_den) << QBITS) <= XW'(i_num);
    end

    for (genvar j = 1; j <= QBITS; j++) begin : g_stage
        logic [XW-1:0] w_sh;
        logic          w_ge;
        assign w_sh = XW'(r_d[j-1]) << (QBITS - j);
        assign w_ge = r_rem[j-1] >= w_sh;
        always_ff @(posedge i_clk) begin
            r_rem[j] <= w_ge ? (r_rem[j-1] - w_sh) : r_rem[j-1];
            r_q[j]   <= r_q[j-1] | (QBITS'(w_ge) << (QBITS - j));
            r_d[j]   <= r_d[j-1];
            r_sat[j] <= r_sat[j-1];
        end
    end

    assign o_quot    = r_q[QBITS];
    assign o_inexact = r_rem[QBITS] != '0;
    assign o_sat     = r_sat[QBITS];

endmodule

### hw/rtl/wepp_front.sv
// ----------------------------------------------------------------------------
// Projector front end
// Moves both vertices into view space and classifies whether the edge is visible.
// ----------------------------------------------------------------------------
module wepp_front
    import wepp_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic signed [CW-1:0]  i_start_x,
    input  logic signed [CW-1:0]  i_start_y,
    input  logic signed [CW-1:0]  i_end_x,
    input  logic signed [CW-1:0]  i_end_y,
    input  logic signed [CW-1:0]  i_floor_level,
    input  logic signed [CW-1:0]  i_ceiling_level,
    input  logic signed [CW-1:0]  i_player_x,
    input  logic signed [CW-1:0]  i_player_y,
    input  logic signed [CW-1:0]  i_eye_height,
    input  t_view_cfg             i_view,
    output logic                  o_push,
    output logic [1+4+4*(CW+17)+2*CW-1:0] o_word
);

    localparam int VW = CW + 1;
    localparam int PW = CW + 18;
    localparam int LW = CW + 17;

    logic                 r_v1, r_v2;
    logic signed [VW-1:0] r_dx0, r_dy0, r_dx1, r_dy1, r_lvc, r_lvf;
    logic signed [VW-1:0] r_lvc2, r_lvf2;
    logic signed [PW-1:0] r_dep0, r_dep1, r_lat0, r_lat1;

    logic          w_vis;
    logic [LW-1:0] w_ml0, w_ml1, w_d0, w_d1;
    logic [CW-1:0] w_mc, w_mf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx0 <= VW'(i_start_x) - VW'(i_player_x);
        r_dy0 <= VW'(i_start_y) - VW'(i_player_y);
        r_dx1 <= VW'(i_end_x) - VW'(i_player_x);
        r_dy1 <= VW'(i_end_y) - VW'(i_player_y);
        r_lvc <= VW'(i_ceiling_level) - VW'(i_eye_height);
        r_lvf <= VW'(i_floor_level) - VW'(i_eye_height);
        r_dep0 <= PW'(r_dx0 * i_view.cos_angle) + PW'(r_dy0 * i_view.sin_angle);
        r_lat0 <= PW'(r_dy0 * i_view.cos_angle) - PW'(r_dx0 * i_view.sin_angle);
        r_dep1 <= PW'(r_dx1 * i_view.cos_angle) + PW'(r_dy1 * i_view.sin_angle);
        r_lat1 <= PW'(r_dy1 * i_view.cos_angle) - PW'(r_dx1 * i_view.sin_angle);
        r_lvc2 <= r_lvc;
        r_lvf2 <= r_lvf;
    end

    always_comb begin
        w_vis = (r_dep0 > 0) && (r_dep1 > 0);
        w_ml0 = LW'((r_lat0 < 0) ? -r_lat0 : r_lat0);
        w_ml1 = LW'((r_lat1 < 0) ? -r_lat1 : r_lat1);
        w_d0  = LW'(r_dep0);
        w_d1  = LW'(r_dep1);
        w_mc  = CW'((r_lvc2 < 0) ? -r_lvc2 : r_lvc2);
        w_mf  = CW'((r_lvf2 < 0) ? -r_lvf2 : r_lvf2);
    end

    assign o_push = r_v2;
    assign o_word = {w_vis, r_lat0 < 0, r_lat1 < 0, r_lvc2 > 0, r_lvf2 > 0,
                     w_ml0, w_ml1, w_d0, w_d1, w_mc, w_mf};

endmodule

### hw/rtl/wepp_queue.sv
// ----------------------------------------------------------------------------
// Edge queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module wepp_queue
    import wepp_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    output logic             o_almost_full
);

    localparam int AW = $clog2(QDEPTH);

    logic [WIDTH-1:0] r_mem [0:QDEPTH-1];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_count;
    logic             w_pop;

    assign w_pop = r_count != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            r_count <= r_count + (AW+1)'(i_push) - (AW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid       = w_pop;
    assign o_data        = r_mem[r_rd];
    assign o_almost_full = r_count >= (AW+1)'(QDEPTH - 2);

endmodule

### hw/rtl/wepp_back.sv
// ----------------------------------------------------------------------------
// Projector back end
// Scales, divides by depth and places each edge end on the screen.
// ----------------------------------------------------------------------------
module wepp_back
    import wepp_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [1+4+4*(CW+17)+2*CW-1:0] i_word,
    input  t_view_cfg                   i_view,
    output logic                        o_valid,
    output logic                        o_visible,
    output logic signed [OUT_W-1:0]     o_screen_x_start,
    output logic signed [OUT_W-1:0]     o_screen_x_end,
    output logic signed [OUT_W-1:0]     o_ceil_y_start,
    output logic signed [OUT_W-1:0]     o_floor_y_start,
    output logic signed [OUT_W-1:0]     o_ceil_y_end,
    output logic signed [OUT_W-1:0]     o_floor_y_end
);

    localparam int LW  = CW + 17;
    localparam int CNW = LW + FOV_W;
    localparam int RNW = CW + FOV_W;

    function automatic logic signed [OUT_W-1:0] place(
        input logic [CTR_W-1:0] center,
        input logic             neg,
        input logic [QBITS-1:0] q,
        input logic             inx,
        input logic             sat
    );
        logic signed [19:0] c;
        logic signed [19:0] qq;
        logic signed [19:0] v;
        c  = signed'(20'(center));
        qq = signed'(20'(q));
        if (!neg) begin
            v = c + qq;
        end else begin
            v = c - qq - 20'(inx);
            if (v < 0) begin
                v = c - qq;
            end
        end
        if (sat) begin
            v = neg ? -20'sd32768 : 20'sd32767;
        end
        if (v > 20'sd32767) begin
            v = 20'sd32767;
        end else if (v < -20'sd32768) begin
            v = -20'sd32768;
        end
        return OUT_W'(v);
    endfunction

    logic          w_vis, w_nl0, w_nl1, w_nc, w_nf;
    logic [LW-1:0] w_ml0, w_ml1, w_d0, w_d1;
    logic [CW-1:0] w_mc, w_mf;

    assign {w_vis, w_nl0, w_nl1, w_nc, w_nf, w_ml0, w_ml1, w_d0, w_d1, w_mc, w_mf} = i_word;

    logic           r_bv;
    logic [4:0]     r_bsb;
    logic [CNW-1:0] r_ncol0, r_ncol1;
    logic [RNW-1:0] r_nrc, r_nrf;
    logic [LW-1:0]  r_dep0, r_dep1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
        end else begin
            r_bv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bsb   <= {w_vis, w_nl0, w_nl1, w_nc, w_nf};
        r_ncol0 <= w_ml0 * i_view.fov_scale;
        r_ncol1 <= w_ml1 * i_view.fov_scale;
        r_nrc   <= w_mc * i_view.fov_scale;
        r_nrf   <= w_mf * i_view.fov_scale;
        r_dep0  <= w_d0;
        r_dep1  <= w_d1;
    end

    logic [QBITS-1:0] w_q [0:5];
    logic             w_inx [0:5];
    logic             w_sat [0:5];

    wepp_div #(.NW(CNW), .DW(LW+6)) u_div_col0 (
        .i_clk(i_clk), .i_num(r_ncol0), .i_den({r_dep0, 6'b0}),
        .o_quot(w_q[0]), .o_inexact(w_inx[0]), .o_sat(w_sat[0]));
    wepp_div #(.NW(CNW), .DW(LW+6)) u_div_col1 (
        .i_clk(i_clk), .i_num(r_ncol1), .i_den({r_dep1, 6'b0}),
        .o_quot(w_q[1]), .o_inexact(w_inx[1]), .o_sat(w_sat[1]));
    wepp_div #(.NW(RNW+8), .DW(LW)) u_div_cs (
        .i_clk(i_clk), .i_num({r_nrc, 8'b0}), .i_den(r_dep0),
        .o_quot(w_q[2]), .o_inexact(w_inx[2]), .o_sat(w_sat[2]));
    wepp_div #(.NW(RNW+8), .DW(LW)) u_div_fs (
        .i_clk(i_clk), .i_num({r_nrf, 8'b0}), .i_den(r_dep0),
        .o_quot(w_q[3]), .o_inexact(w_inx[3]), .o_sat(w_sat[3]));
    wepp_div #(.NW(RNW+8), .DW(LW)) u_div_ce (
        .i_clk(i_clk), .i_num({r_nrc, 8'b0}), .i_den(r_dep1),
        .o_quot(w_q[4]), .o_inexact(w_inx[4]), .o_sat(w_sat[4]));
    wepp_div #(.NW(RNW+8), .DW(LW)) u_div_fe (
        .i_clk(i_clk), .i_num({r_nrf, 8'b0}), .i_den(r_dep1),
        .o_quot(w_q[5]), .o_inexact(w_inx[5]), .o_sat(w_sat[5]));

    logic       r_sv  [0:DIV_LAT-1];
    logic [4:0] r_ssb [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_sv[i] <= 1'b0;
            end
        end else begin
            r_sv[0] <= r_bv;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_sv[i] <= r_sv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ssb[0] <= r_bsb;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_ssb[i] <= r_ssb[i-1];
        end
    end

    logic       r_valid;
    logic [4:0] w_sb;

    assign w_sb = r_ssb[DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_sv[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_visible <= w_sb[4];
        if (w_sb[4]) begin
            o_screen_x_start <= place(i_view.half_width, w_sb[3], w_q[0], w_inx[0], w_sat[0]);
            o_screen_x_end   <= place(i_view.half_width, w_sb[2], w_q[1], w_inx[1], w_sat[1]);
            o_ceil_y_start   <= place(i_view.half_height, w_sb[1], w_q[2], w_inx[2], w_sat[2]);
            o_floor_y_start  <= place(i_view.half_height, w_sb[0], w_q[3], w_inx[3], w_sat[3]);
            o_ceil_y_end     <= place(i_view.half_height, w_sb[1], w_q[4], w_inx[4], w_sat[4]);
            o_floor_y_end    <= place(i_view.half_height, w_sb[0], w_q[5], w_inx[5], w_sat[5]);
        end else begin
            o_screen_x_start <= '0;
            o_screen_x_end   <= '0;
            o_ceil_y_start   <= '0;
            o_floor_y_start  <= '0;
            o_ceil_y_end     <= '0;
            o_floor_y_end    <= '0;
        end
    end

    assign o_valid = r_valid;

endmodule

### hw/rtl/wepp_checker.sv
// ----------------------------------------------------------------------------
// Projector port checker
// Checks latency and result framing on the ports of the projector.
// ----------------------------------------------------------------------------
module wepp_checker
    import wepp_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    o_valid,
    input logic                    o_visible,
    input logic signed [OUT_W-1:0] o_screen_x_start,
    input logic signed [OUT_W-1:0] o_screen_x_end,
    input logic signed [OUT_W-1:0] o_ceil_y_start,
    input logic signed [OUT_W-1:0] o_floor_y_start,
    input logic signed [OUT_W-1:0] o_ceil_y_end,
    input logic signed [OUT_W-1:0] o_floor_y_end
);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##23 o_valid)
        else $error("Accepted item did not produce a result on time.");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 23))
        else $error("Result appeared without an accepted item.");

    a_invisible_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_visible) |-> (o_screen_x_start == 0 && o_screen_x_end == 0 &&
        o_ceil_y_start == 0 && o_floor_y_start == 0 && o_ceil_y_end == 0 &&
        o_floor_y_end == 0))
        else $error("Invisible edge carries nonzero fields.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result strobe after reset.");

endmodule

bind wall_edge_perspective_projector_core wepp_checker u_wepp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_visible(o_visible),
    .o_screen_x_start(o_screen_x_start), .o_screen_x_end(o_screen_x_end),
    .o_ceil_y_start(o_ceil_y_start), .o_floor_y_start(o_floor_y_start),
    .o_ceil_y_end(o_ceil_y_end), .o_floor_y_end(o_floor_y_end));

### tb/tb_wall_edge_perspective_projector_core.sv
// ----------------------------------------------------------------------------
// Wall edge perspective projector testbench
// Drives wall edges through the command port and view settings through the
// APB port, predicts projected edges in the bench or takes a given expectation
// for directed edges, and checks every result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_wall_edge_perspective_projector_core;
    import wepp_pkg::*;

    typedef struct {
        logic signed [15:0] sx, sy, ex, ey, fl, cl;
    } t_wall;

    typedef struct {
        logic               vis;
        logic signed [15:0] xs, xe, cys, fys, cye, fye;
    } t_proj;

    typedef struct {
        t_wall w;
        bit    has_exp;
        t_proj exp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] i_start_x = '0, i_start_y = '0, i_end_x = '0, i_end_y = '0;
    logic signed [15:0] i_floor_level = '0, i_ceiling_level = '0;
    logic o_valid, o_visible;
    logic signed [15:0] o_screen_x_start, o_screen_x_end;
    logic signed [15:0] o_ceil_y_start, o_floor_y_start, o_ceil_y_end, o_floor_y_end;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    logic signed [15:0] view_px, view_py, view_cos, view_sin, view_eye;
    logic [15:0] view_fov;
    logic [11:0] view_hw, view_hh;

    t_proj expected_edges[$];
    int mismatches = 0;
    int burst_left = 0;

    wall_edge_perspective_projector_core dut (.*);

    always #2 i_clk = ~i_clk;

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic signed [15:0] place_row(longint center, bit neg,
                                                   longint unsigned num,
                                                   longint unsigned den);
        longint unsigned q;
        longint v;
        bit inexact;
        q = num / den;
        inexact = (num % den) != 0;
        if (q > 64'd1 << 40) q = 64'd1 << 40;
        if (!neg) begin
            v = center + longint'(q);
        end else begin
            v = center - longint'(q) - (inexact ? 1 : 0);
            if (v < 0) v = center - longint'(q);
        end
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_proj project_edge(t_wall w);
        t_proj r;
        longint dx0, dy0, dx1, dy1, d0, d1, l0, l1, lc, lf, c, s, f;
        c = view_cos;
        s = view_sin;
        f = longint'(view_fov);
        dx0 = longint'(w.sx) - view_px;
        dy0 = longint'(w.sy) - view_py;
        dx1 = longint'(w.ex) - view_px;
        dy1 = longint'(w.ey) - view_py;
        d0 = dx0 * c + dy0 * s;
        d1 = dx1 * c + dy1 * s;
        l0 = dy0 * c - dx0 * s;
        l1 = dy1 * c - dx1 * s;
        lc = longint'(w.cl) - view_eye;
        lf = longint'(w.fl) - view_eye;
        r = '{1'b0, '0, '0, '0, '0, '0, '0};
        if (d0 > 0 && d1 > 0) begin
            r.vis = 1'b1;
            r.xs  = place_row(view_hw, l0 < 0, (l0 < 0 ? -l0 : l0) * f, d0 * 64);
            r.xe  = place_row(view_hw, l1 < 0, (l1 < 0 ? -l1 : l1) * f, d1 * 64);
            r.cys = place_row(view_hh, lc > 0, (lc < 0 ? -lc : lc) * f * 256, d0);
            r.fys = place_row(view_hh, lf > 0, (lf < 0 ? -lf : lf) * f * 256, d0);
            r.cye = place_row(view_hh, lc > 0, (lc < 0 ? -lc : lc) * f * 256, d1);
            r.fye = place_row(view_hh, lf > 0, (lf < 0 ? -lf : lf) * f * 256, d1);
        end
        return r;
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = {16'($urandom_range(0, 65535)), val};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_PLAYER_X:    view_px = val;
            REG_PLAYER_Y:    view_py = val;
            REG_COS_ANGLE:   view_cos = val;
            REG_SIN_ANGLE:   view_sin = val;
            REG_EYE_HEIGHT:  view_eye = val;
            REG_FOV_SCALE:   view_fov = val;
            REG_HALF_WIDTH:  view_hw = val[11:0];
            REG_HALF_HEIGHT: view_hh = val[11:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic drain();
        while (expected_edges.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_view(logic [15:0] px, logic [15:0] py, logic [15:0] c,
                            logic [15:0] s, logic [15:0] eye, logic [15:0] f,
                            logic [15:0] hw, logic [15:0] hh);
        drain();
        write_reg(REG_PLAYER_X, px);
        write_reg(REG_PLAYER_Y, py);
        write_reg(REG_COS_ANGLE, c);
        write_reg(REG_SIN_ANGLE, s);
        write_reg(REG_EYE_HEIGHT, eye);
        write_reg(REG_FOV_SCALE, f);
        write_reg(REG_HALF_WIDTH, hw);
        write_reg(REG_HALF_HEIGHT, hh);
    endtask

    task automatic send_edge(t_wall w, bit has_exp, t_proj exp);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            repeat (gap) begin
                @(negedge i_clk);
                start = 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge i_clk);
        start = 1'b1;
        i_start_x = w.sx;
        i_start_y = w.sy;
        i_end_x = w.ex;
        i_end_y = w.ey;
        i_floor_level = w.fl;
        i_ceiling_level = w.cl;
        do @(posedge i_clk); while (busy);
        expected_edges.push_back(has_exp ? exp : project_edge(w));
    endtask

    function automatic logic signed [15:0] near(logic signed [15:0] base);
        int v;
        v = int'(base) + $urandom_range(0, 8000) - 4000;
        return v[15:0];
    endfunction

    function automatic t_wall random_edge();
        t_wall w;
        t_proj p;
        if ($urandom_range(0, 9) < 3) begin
            w = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom)};
        end else begin
            for (int t = 0; t < 16; t++) begin
                w.sx = near(view_px);
                w.sy = near(view_py);
                w.ex = near(view_px);
                w.ey = near(view_py);
                w.fl = $urandom_range(0, 1) ? near(view_eye) : 16'($urandom);
                w.cl = $urandom_range(0, 1) ? near(view_eye) : 16'($urandom);
                p = project_edge(w);
                if (p.vis) break;
            end
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_proj e;
        if (i_rst_n && o_valid) begin
            if (expected_edges.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result at %0t", $realtime);
            end else begin
                e = expected_edges.pop_front();
                if (o_visible !== e.vis || o_screen_x_start !== e.xs
                        || o_screen_x_end !== e.xe || o_ceil_y_start !== e.cys
                        || o_floor_y_start !== e.fys || o_ceil_y_end !== e.cye
                        || o_floor_y_end !== e.fye) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display(
                            "exp %0d %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d %0d",
                            e.vis, e.xs, e.xe, e.cys, e.fys, e.cye, e.fye,
                            o_visible, o_screen_x_start, o_screen_x_end,
                            o_ceil_y_start, o_floor_y_start, o_ceil_y_end,
                            o_floor_y_end);
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_proj hidden;
        hidden = '{1'b0, '0, '0, '0, '0, '0, '0};
        view_px = 0;
        view_py = 0;
        view_cos = 16384;
        view_sin = 0;
        view_eye = 512;
        view_fov = 39114;
        view_hw = 480;
        view_hh = 270;

        rows.push_back('{'{0, 0, 16, 0, 0, 1024}, 1, hidden});
        rows.push_back('{'{16, 0, 0, 0, 0, 1024}, 1, hidden});
        rows.push_back('{'{-16, 5, 16, 5, 0, 1024}, 1, hidden});
        rows.push_back('{'{32767, 0, -32768, 0, 0, 0}, 1, hidden});
        rows.push_back('{'{-32768, 32767, -32768, -32768, 32767, -32768}, 1, hidden});
        rows.push_back('{'{16, 0, 32, 0, 0, 1024}, 0, hidden});
        rows.push_back('{'{16, -16, 16, 16, 0, 1024}, 0, hidden});
        rows.push_back('{'{1, 32767, 1, -32768, -32768, 32767}, 0, hidden});
        rows.push_back('{'{32767, 32767, 32767, -32768, 32767, -32768}, 0, hidden});
        rows.push_back('{'{32767, 0, 1, 0, 512, 512}, 0, hidden});
        rows.push_back('{'{160, 80, 320, -80, -32768, 32767}, 0, hidden});
        rows.push_back('{'{1, 1, 1, -1, 0, 0}, 0, hidden});

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) send_edge(rows[i].w, rows[i].has_exp, rows[i].exp);

        for (int ph = 0; ph < 8; ph++) begin
            @(negedge i_clk);
            start = 1'b0;
            case (ph)
                0: set_view(0, 0, 16384, 0, 512, 0, 480, 270);
                1: set_view(16'h7fff, 16'h8000, 16'hc000, 16'h4000, 16'h7fff,
                            16'hffff, 16'h0fff, 16'h0fff);
                2: set_view(16'h8000, 16'h7fff, 16'h4000, 16'hc000, 16'h8000,
                            16'hffff, 0, 0);
                3: set_view(16'($urandom), 16'($urandom), 16'h7fff, 16'h8000,
                            16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom));
                default: set_view(16'($urandom), 16'($urandom),
                                  16'($urandom_range(0, 32768) - 16384),
                                  16'($urandom_range(0, 32768) - 16384),
                                  16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom));
            endcase
            repeat (250) send_edge(random_edge(), 0, hidden);
        end

        @(negedge i_clk);
        start = 1'b0;
        drain();
        if (mismatches == 0 && expected_edges.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
